// ===== sv/cdad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cdad_pkg;

   localparam int FIRST_YEAR = 1970;
   localparam int LAST_YEAR  = 2099;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int OFF_W   = 17;
   localparam int YLEN_W  = 9;
   localparam int Y100_W  = 7;
   localparam int Y400_W  = 9;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   function automatic bit leap_const(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int total_days();
      int t;
      t = 0;
      for (int y = FIRST_YEAR; y <= LAST_YEAR; y++) begin
         t = t + (leap_const(y) ? 366 : 365);
      end
      return t;
   endfunction

   localparam int TOTAL_DAYS = total_days();
   localparam int OFF_SPAN   = 2 ** (OFF_W - 1);
   // signed day count: holds every in-range date plus the largest offset
   localparam int CNT_W      = $clog2(TOTAL_DAYS + OFF_SPAN + 1) + 1;

   localparam logic [Y100_W-1:0] FIRST_Y100 = Y100_W'(FIRST_YEAR % 100);
   localparam logic [Y400_W-1:0] FIRST_Y400 = Y400_W'(FIRST_YEAR % 400);
   localparam logic [Y100_W-1:0] LAST_Y100  = Y100_W'(99);
   localparam logic [Y400_W-1:0] LAST_Y400  = Y400_W'(399);

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_INIT,
      DP_ADD_YEAR,
      DP_ADD_MONTH,
      DP_ADD_DAY,
      DP_REWIND,
      DP_SUB_YEAR,
      DP_SUB_MONTH,
      DP_EMIT_OK,
      DP_EMIT_ERR
   } dp_op_type;

   typedef enum logic [3:0] {
      COND_REQ,
      COND_BAD_INPUT,
      COND_YEAR_HIT,
      COND_MONTH_HIT,
      COND_BAD_DAY,
      COND_OUT_RANGE,
      COND_YEAR_FITS,
      COND_MONTH_FITS,
      COND_SLOT_FREE
   } cond_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_CHECK,
      STEP_YWALK_UP,
      STEP_MWALK_UP,
      STEP_DAY,
      STEP_RANGE,
      STEP_YWALK_DOWN,
      STEP_MWALK_DOWN,
      STEP_EMIT_OK,
      STEP_EMIT_ERR
   } step_type;

   typedef struct packed {
      cond_type  cond;
      dp_op_type op_t;
      step_type  next_t;
      dp_op_type op_f;
      step_type  next_f;
   } ucode_type;

   typedef struct packed {
      logic bad_input;
      logic year_hit;
      logic month_hit;
      logic bad_day;
      logic out_range;
      logic year_fits;
      logic month_fits;
   } dp_flags_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                     len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:  len = DAY_W'(30);
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:       len = DAY_W'(31);
         default:                  len = '0;
      endcase
      return len;
   endfunction

   // control store: on condition true take op_t/next_t, else op_f/next_f
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      unique case (s)
         STEP_IDLE:       w = '{COND_REQ,        DP_LOAD,      STEP_CHECK,
                                DP_NONE,         STEP_IDLE};
         STEP_CHECK:      w = '{COND_BAD_INPUT,  DP_NONE,      STEP_EMIT_ERR,
                                DP_INIT,         STEP_YWALK_UP};
         STEP_YWALK_UP:   w = '{COND_YEAR_HIT,   DP_NONE,      STEP_MWALK_UP,
                                DP_ADD_YEAR,     STEP_YWALK_UP};
         STEP_MWALK_UP:   w = '{COND_MONTH_HIT,  DP_NONE,      STEP_DAY,
                                DP_ADD_MONTH,    STEP_MWALK_UP};
         STEP_DAY:        w = '{COND_BAD_DAY,    DP_NONE,      STEP_EMIT_ERR,
                                DP_ADD_DAY,      STEP_RANGE};
         STEP_RANGE:      w = '{COND_OUT_RANGE,  DP_NONE,      STEP_EMIT_ERR,
                                DP_REWIND,       STEP_YWALK_DOWN};
         STEP_YWALK_DOWN: w = '{COND_YEAR_FITS,  DP_SUB_YEAR,  STEP_YWALK_DOWN,
                                DP_NONE,         STEP_MWALK_DOWN};
         STEP_MWALK_DOWN: w = '{COND_MONTH_FITS, DP_SUB_MONTH, STEP_MWALK_DOWN,
                                DP_NONE,         STEP_EMIT_OK};
         STEP_EMIT_OK:    w = '{COND_SLOT_FREE,  DP_EMIT_OK,   STEP_IDLE,
                                DP_NONE,         STEP_EMIT_OK};
         STEP_EMIT_ERR:   w = '{COND_SLOT_FREE,  DP_EMIT_ERR,  STEP_IDLE,
                                DP_NONE,         STEP_EMIT_ERR};
         default:         w = '{COND_REQ,        DP_NONE,      STEP_IDLE,
                                DP_NONE,         STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== sv/cdad_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cdad_req_if;
   import cdad_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [DAY_W-1:0]          start_day;
   logic [MONTH_W-1:0]        start_month;
   logic [YEAR_W-1:0]         start_year;
   logic signed [OFF_W-1:0]   day_offset;

   modport source (output valid, start_day, start_month, start_year, day_offset,
                   input ready);
   modport sink   (input valid, start_day, start_month, start_year, day_offset,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/cdad_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cdad_rsp_if;
   import cdad_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DAY_W-1:0]      result_day;
   logic [MONTH_W-1:0]    result_month;
   logic [YEAR_W-1:0]     result_year;
   logic                  range_error;

   modport source (output valid, result_day, result_month, result_year, range_error,
                   input ready);
   modport sink   (input valid, result_day, result_month, result_year, range_error,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/cdad_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdad_datapath (
   input  wire                              clock,
   input  var cdad_pkg::dp_op_type          op,
   input  wire [cdad_pkg::DAY_W-1:0]        in_day,
   input  wire [cdad_pkg::MONTH_W-1:0]      in_month,
   input  wire [cdad_pkg::YEAR_W-1:0]       in_year,
   input  wire signed [cdad_pkg::OFF_W-1:0] in_offset,
   output cdad_pkg::dp_flags_type           flags,
   output logic [cdad_pkg::DAY_W-1:0]       out_day,
   output logic [cdad_pkg::MONTH_W-1:0]     out_month,
   output logic [cdad_pkg::YEAR_W-1:0]      out_year
);
   import cdad_pkg::*;

   logic [DAY_W-1:0]         d_ff, d_in;
   logic [MONTH_W-1:0]       m_ff, m_in;
   logic [YEAR_W-1:0]        y_ff, y_in;
   logic signed [OFF_W-1:0]  off_ff, off_in;
   logic signed [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [YEAR_W-1:0]        yy_ff, yy_in;
   logic [Y100_W-1:0]        y100_ff, y100_in;
   logic [Y400_W-1:0]        y400_ff, y400_in;
   logic [MONTH_W-1:0]       mm_ff, mm_in;

   logic                     leap;
   logic [YLEN_W-1:0]        ylen;
   logic [DAY_W-1:0]         mlen;
   logic [CNT_W-2:0]         cnt_mag;

   assign leap    = ((yy_ff[1:0] == 2'd0) && (y100_ff != '0)) || (y400_ff == '0);
   assign ylen    = leap ? YLEN_W'(366) : YLEN_W'(365);
   assign mlen    = month_len(mm_ff, leap);
   assign cnt_mag = cnt_ff[CNT_W-2:0];

   always_comb begin
      flags.bad_input  = (y_ff < YEAR_W'(FIRST_YEAR)) || (y_ff > YEAR_W'(LAST_YEAR)) ||
                         (m_ff < MONTH_JAN) || (m_ff > MONTH_DEC) || (d_ff == '0);
      flags.year_hit   = (yy_ff == y_ff);
      flags.month_hit  = (mm_ff == m_ff);
      flags.bad_day    = (d_ff > mlen);
      flags.out_range  = cnt_ff[CNT_W-1] || (cnt_mag >= (CNT_W-1)'(TOTAL_DAYS));
      flags.year_fits  = (cnt_mag >= (CNT_W-1)'(ylen));
      flags.month_fits = (mm_ff < MONTH_DEC) && (cnt_mag >= (CNT_W-1)'(mlen));
   end

   always_comb begin
      d_in    = d_ff;
      m_in    = m_ff;
      y_in    = y_ff;
      off_in  = off_ff;
      cnt_in  = cnt_ff;
      yy_in   = yy_ff;
      y100_in = y100_ff;
      y400_in = y400_ff;
      mm_in   = mm_ff;
      unique case (op)
         DP_LOAD: begin
            d_in   = in_day;
            m_in   = in_month;
            y_in   = in_year;
            off_in = in_offset;
         end
         DP_INIT, DP_REWIND: begin
            if (op == DP_INIT) begin
               cnt_in = '0;
            end
            yy_in   = YEAR_W'(FIRST_YEAR);
            y100_in = FIRST_Y100;
            y400_in = FIRST_Y400;
            mm_in   = MONTH_JAN;
         end
         DP_ADD_YEAR, DP_SUB_YEAR: begin
            if (op == DP_ADD_YEAR) begin
               cnt_in = cnt_ff + CNT_W'(ylen);
            end else begin
               cnt_in = cnt_ff - CNT_W'(ylen);
            end
            // advance the year and its century phase counters together
            yy_in   = yy_ff + YEAR_W'(1);
            y100_in = (y100_ff == LAST_Y100) ? '0 : y100_ff + Y100_W'(1);
            y400_in = (y400_ff == LAST_Y400) ? '0 : y400_ff + Y400_W'(1);
         end
         DP_ADD_MONTH, DP_SUB_MONTH: begin
            if (op == DP_ADD_MONTH) begin
               cnt_in = cnt_ff + CNT_W'(mlen);
            end else begin
               cnt_in = cnt_ff - CNT_W'(mlen);
            end
            mm_in = mm_ff + MONTH_W'(1);
         end
         DP_ADD_DAY: begin
            cnt_in = cnt_ff + CNT_W'(d_ff) - CNT_W'(1) + CNT_W'(off_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      m_ff    <= m_in;
      y_ff    <= y_in;
      off_ff  <= off_in;
      cnt_ff  <= cnt_in;
      yy_ff   <= yy_in;
      y100_ff <= y100_in;
      y400_ff <= y400_in;
      mm_ff   <= mm_in;
   end

   assign out_day   = cnt_ff[DAY_W-1:0] + DAY_W'(1);
   assign out_month = mm_ff;
   assign out_year  = yy_ff;

endmodule
`default_nettype wire

// ===== sv/calendar_date_add_days_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Adds a signed day offset to a Gregorian date between 1 January 1970 and
// 31 December 2099 and returns the resulting date, one result per item. An
// invalid start date, or a sum outside the supported years, raises
// range_error and returns 1 January 1970. Work is done by a small microcoded
// sequencer that walks years and months through one shared accumulator: it
// walks up from 1970 to the start year and month, adds the day and offset,
// checks the range and walks the sum down to the result year and month; a
// result waits in its emit step until the output register is free. A start
// year or month out of range, or a zero day, ends at the check step, a bad
// day after the upward walks, and a sum out of range at the range step. A
// new item is taken as soon as the sequencer is back at idle, even while
// the previous result still waits in the output register.
module calendar_date_add_days_unit (
   input  wire         clock,
   input  wire         reset,
   cdad_req_if.sink    req_if,
   cdad_rsp_if.source  rsp_if
);
   import cdad_pkg::*;

   step_type      step_ff, step_in;
   ucode_type     uword;
   dp_flags_type  flags;
   dp_op_type     op;
   logic          cond_true;
   logic          slot_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]      rsp_day_ff, rsp_day_in;
   logic [MONTH_W-1:0]    rsp_month_ff, rsp_month_in;
   logic [YEAR_W-1:0]     rsp_year_ff, rsp_year_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic [DAY_W-1:0]      dp_day;
   logic [MONTH_W-1:0]    dp_month;
   logic [YEAR_W-1:0]     dp_year;

   assign uword     = ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      unique case (uword.cond)
         COND_REQ:        cond_true = req_if.valid;
         COND_BAD_INPUT:  cond_true = flags.bad_input;
         COND_YEAR_HIT:   cond_true = flags.year_hit;
         COND_MONTH_HIT:  cond_true = flags.month_hit;
         COND_BAD_DAY:    cond_true = flags.bad_day;
         COND_OUT_RANGE:  cond_true = flags.out_range;
         COND_YEAR_FITS:  cond_true = flags.year_fits;
         COND_MONTH_FITS: cond_true = flags.month_fits;
         COND_SLOT_FREE:  cond_true = slot_free;
         default:         cond_true = 1'b0;
      endcase
      op      = cond_true ? uword.op_t   : uword.op_f;
      step_in = cond_true ? uword.next_t : uword.next_f;
   end

   assign req_if.ready = (step_ff == STEP_IDLE) && !reset;

   cdad_datapath u_datapath (
      .clock     (clock),
      .op        (op),
      .in_day    (req_if.start_day),
      .in_month  (req_if.start_month),
      .in_year   (req_if.start_year),
      .in_offset (req_if.day_offset),
      .flags     (flags),
      .out_day   (dp_day),
      .out_month (dp_month),
      .out_year  (dp_year)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (op)
         DP_EMIT_OK: begin
            rsp_valid_in = 1'b1;
            rsp_day_in   = dp_day;
            rsp_month_in = dp_month;
            rsp_year_in  = dp_year;
            rsp_err_in   = 1'b0;
         end
         DP_EMIT_ERR: begin
            rsp_valid_in = 1'b1;
            rsp_day_in   = DAY_W'(1);
            rsp_month_in = MONTH_JAN;
            rsp_year_in  = YEAR_W'(FIRST_YEAR);
            rsp_err_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_day   = rsp_day_ff;
   assign rsp_if.result_month = rsp_month_ff;
   assign rsp_if.result_year  = rsp_year_ff;
   assign rsp_if.range_error  = rsp_err_ff;

`ifndef SYNTH
   a_accept_starts_check: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (step_ff == STEP_CHECK))
      else $error("accepted item did not start the check step");

   a_error_gives_epoch: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.range_error) |->
         (rsp_if.result_day == DAY_W'(1)) && (rsp_if.result_month == MONTH_JAN) &&
         (rsp_if.result_year == YEAR_W'(FIRST_YEAR)))
      else $error("error result is not the epoch date");

   a_good_result_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.range_error) |->
         (rsp_if.result_year >= YEAR_W'(FIRST_YEAR)) &&
         (rsp_if.result_year <= YEAR_W'(LAST_YEAR)) &&
         (rsp_if.result_day != '0) && (rsp_if.result_month != '0) &&
         (rsp_if.result_month <= MONTH_DEC))
      else $error("valid result lies outside the supported calendar");

   a_emit_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> (op != DP_EMIT_OK) && (op != DP_EMIT_ERR))
      else $error("result written over a waiting item");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_calendar_date_add_days_unit.sv =====
`timescale 1ns / 1ps
module tb_calendar_date_add_days_unit;
   import cdad_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int LONG_HOLD     = 600;

   typedef struct {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               range_error;
   } date_result_type;

   logic clock = 1'b0;
   logic reset;

   cdad_req_if req_ch ();
   cdad_rsp_if rsp_ch ();

   calendar_date_add_days_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   date_result_type pending_dates[$];
   int error_count  = 0;
   int cycle_count  = 0;
   int rsp_hold_len = 0;
   bit no_gaps      = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_calendar_date_add_days_unit: done, errors");
         $finish;
      end
   end

   function automatic bit is_leap(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int y, input int m);
      case (m)
         2:              return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:    return 30;
         1, 3, 5, 7, 8,
         10, 12:         return 31;
         default:        return 0;
      endcase
   endfunction

   function automatic int days_in_year(input int y);
      return is_leap(y) ? 366 : 365;
   endfunction

   function automatic int supported_span();
      int n;
      n = 0;
      for (int y = FIRST_YEAR; y <= LAST_YEAR; y++) n += days_in_year(y);
      return n;
   endfunction

   function automatic int days_since_epoch(input int d, input int m, input int y);
      int n;
      n = d - 1;
      for (int i = FIRST_YEAR; i < y; i++) n += days_in_year(i);
      for (int i = 1; i < m; i++) n += days_in_month(y, i);
      return n;
   endfunction

   function automatic date_result_type add_days_to_date(input logic [DAY_W-1:0] d,
                                                        input logic [MONTH_W-1:0] m,
                                                        input logic [YEAR_W-1:0] y,
                                                        input logic signed [OFF_W-1:0] off);
      date_result_type r;
      int dd, mm, yy, count;
      r.day         = DAY_W'(1);
      r.month       = MONTH_JAN;
      r.year        = YEAR_W'(FIRST_YEAR);
      r.range_error = 1'b1;
      dd = int'(d);
      mm = int'(m);
      yy = int'(y);
      if (yy < FIRST_YEAR || yy > LAST_YEAR || mm < 1 || mm > 12 || dd < 1 ||
          dd > days_in_month(yy, mm))
         return r;
      count = days_since_epoch(dd, mm, yy) + int'(off);
      if (count < 0 || count >= supported_span())
         return r;
      yy = FIRST_YEAR;
      while (count >= days_in_year(yy)) begin
         count -= days_in_year(yy);
         yy++;
      end
      mm = 1;
      while (mm < 12 && count >= days_in_month(yy, mm)) begin
         count -= days_in_month(yy, mm);
         mm++;
      end
      r.day         = DAY_W'(count + 1);
      r.month       = MONTH_W'(mm);
      r.year        = YEAR_W'(yy);
      r.range_error = 1'b0;
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_date(input int d, input int m, input int y, input int off);
      logic [DAY_W-1:0]        dv;
      logic [MONTH_W-1:0]      mv;
      logic [YEAR_W-1:0]       yv;
      logic signed [OFF_W-1:0] ov;
      int gap;
      dv  = DAY_W'(d);
      mv  = MONTH_W'(m);
      yv  = YEAR_W'(y);
      ov  = OFF_W'(off);
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.start_day   = dv;
      req_ch.start_month = mv;
      req_ch.start_year  = yv;
      req_ch.day_offset  = ov;
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_dates.push_back(add_days_to_date(dv, mv, yv, ov));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic make_random_date(output int d, output int m, output int y,
                                   output int off);
      int kind, mlen, target;
      kind = $urandom_range(0, 99);
      y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
      m    = $urandom_range(1, 12);
      mlen = days_in_month(y, m);
      d    = $urandom_range(1, mlen);
      off  = int'($urandom_range(0, 799)) - 400;
      if (kind < 8) begin
         // raw noise over the whole field widths
         d   = $urandom_range(0, 31);
         m   = $urandom_range(0, 15);
         y   = $urandom_range(0, 4095);
         off = $urandom_range(0, 2 ** OFF_W - 1);
      end else if (kind < 14) begin
         d = (mlen == 31) ? 0 : $urandom_range(mlen + 1, 31);
      end else if (kind < 20) begin
         m = 2;
         d = 29;
      end else if (kind < 55) begin
         off = $urandom_range(0, 2 ** OFF_W - 1);
      end else if (kind < 70) begin
         // land just inside or just outside either end of the supported span
         if ($urandom_range(0, 1) == 0)
            target = int'($urandom_range(0, 40)) - 20;
         else
            target = supported_span() - 20 + int'($urandom_range(0, 40));
         off = target - days_since_epoch(d, m, y);
      end
   endtask

   task automatic wait_dates_drained();
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_dates(input int n);
      int d, m, y, off;
      repeat (n) begin
         make_random_date(d, m, y, off);
         send_date(d, m, y, off);
      end
   endtask

   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 13);
         if (rsp_hold_len != 0) begin
            stall        = rsp_hold_len;
            rsp_hold_len = 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      date_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_dates.size() == 0) begin
            $error("unexpected result: %0d-%0d-%0d err %0b", rsp_ch.result_year,
                   rsp_ch.result_month, rsp_ch.result_day, rsp_ch.range_error);
            error_count++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_ch.result_day !== want.day) begin
               $error("result_day: expected %0d, got %0d", want.day, rsp_ch.result_day);
               error_count++;
            end
            if (rsp_ch.result_month !== want.month) begin
               $error("result_month: expected %0d, got %0d", want.month,
                      rsp_ch.result_month);
               error_count++;
            end
            if (rsp_ch.result_year !== want.year) begin
               $error("result_year: expected %0d, got %0d", want.year, rsp_ch.result_year);
               error_count++;
            end
            if (rsp_ch.range_error !== want.range_error) begin
               $error("range_error: expected %0b, got %0b", want.range_error,
                      rsp_ch.range_error);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_edges();
      send_date(1, 1, 1970, 0);
      send_date(1, 1, 1970, -1);
      send_date(31, 12, 2099, 0);
      send_date(31, 12, 2099, 1);
      send_date(1, 1, 1970, 65535);
      send_date(31, 12, 2099, -65535);
      send_date(15, 6, 2030, -65536);
      send_date(1, 1, 1970, 47481);
      send_date(31, 12, 2099, -47481);
      send_date(29, 2, 2000, 0);
      send_date(29, 2, 2001, 0);
      send_date(29, 2, 2096, 365);
      send_date(28, 2, 2099, 1);
      send_date(28, 2, 2000, 1);
      send_date(31, 12, 1999, 1);
      send_date(1, 1, 2099, 365);
      send_date(1, 0, 2000, 0);
      send_date(1, 13, 2000, 0);
      send_date(1, 15, 2000, 0);
      send_date(0, 5, 2000, 0);
      send_date(31, 4, 2000, 0);
      send_date(31, 1, 1980, 30);
      send_date(1, 1, 1969, 0);
      send_date(1, 1, 2100, 0);
      send_date(31, 15, 4095, -1);
   endtask

   task automatic test_random_dates();
      send_random_dates(1450);
   endtask

   task automatic test_no_idle_stretch();
      no_gaps = 1'b1;
      send_random_dates(150);
      no_gaps = 1'b0;
   endtask

   // short walks keep the block quick, so the input stalls behind the held output
   task automatic test_output_backpressure();
      wait_dates_drained();
      rsp_hold_len = LONG_HOLD;
      no_gaps      = 1'b1;
      repeat (12) send_date($urandom_range(1, 28), $urandom_range(1, 12),
                            $urandom_range(FIRST_YEAR, FIRST_YEAR + 3),
                            int'($urandom_range(0, 60)) - 30);
      no_gaps = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (5) begin
         send_random_dates(20);
         wait_dates_drained();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.start_day   = '0;
      req_ch.start_month = '0;
      req_ch.start_year  = '0;
      req_ch.day_offset  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_random_dates();
      test_output_backpressure();
      test_no_idle_stretch();
      test_pause_until_drained();

      wait_dates_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("tb_calendar_date_add_days_unit: done, clean");
      else
         $display("tb_calendar_date_add_days_unit: done, errors");
      $finish;
   end

endmodule
